[src/polar_motion_matrix_macros.svh]
// assertion macros for the polar motion matrix checker
`ifndef POLAR_MOTION_MATRIX_MACROS_SVH
`define POLAR_MOTION_MATRIX_MACROS_SVH

// same-cycle implication, disabled during reset
`define PMM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define PMM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/pmm_pkg.sv]
// shared constants, stage map and types of the polar motion matrix pipeline
package pmm_pkg;

	// field widths, input Q2.61, output Q3.61
	localparam int IN_W = 63;
	localparam int OUT_W = 64;
	localparam int FRAC = 61;

	// limb multiplier geometry
	localparam int LIMB_W = 32;
	localparam int PR_NA = 4;
	localparam int PR_NB = 2;
	localparam int PR_A_W = PR_NA * LIMB_W;
	localparam int PR_B_W = PR_NB * LIMB_W;
	localparam int PR_P_W = PR_A_W + PR_B_W;
	localparam int PR_ROW_W = LIMB_W * (PR_NB + 1);
	localparam int PR_LAT = 3;

	// squares, sum of squares, root
	localparam int SQ2_W = 2 * IN_W - 1;
	localparam int S_W = SQ2_W + 1;
	localparam int SQ_N = FRAC;
	localparam int SQ_W = 2 * SQ_N + 1;

	// divider geometry
	localparam int DIV_N = FRAC + 1;
	localparam int DIV_DW = S_W;
	localparam int DIV_NW = S_W + DIV_N;

	// numeric constants
	localparam logic [OUT_W-1:0] ONE_Q = OUT_W'(1) << FRAC;
	localparam logic [OUT_W-1:0] TINY_S = 64'd5316911983139663492;
	localparam logic [S_W-1:0] UNIT_S = S_W'(1) << (2 * FRAC);

	// stage map, register index of each step
	localparam int P_IN = 0;
	localparam int P_FP = P_IN + PR_LAT;
	localparam int P_S = P_FP + 1;
	localparam int P_SQ0 = P_S + 1;
	localparam int P_SQL = P_SQ0 + SQ_N - 1;
	localparam int P_BP = P_SQL + PR_LAT;
	localparam int P_DV0 = P_BP + 1;
	localparam int P_DVL = P_DV0 + DIV_N - 1;
	localparam int P_OUT = P_DVL + 1;
	localparam int LAT = P_OUT + 1;

	// sideband that rides along the pipeline
	typedef struct packed {
		logic signed [IN_W-1:0] xs;
		logic signed [IN_W-1:0] ys;
		logic [IN_W-1:0] xm;
		logic [IN_W-1:0] ym;
		logic negp;
		logic tiny;
		logic dom;
		logic [SQ2_W-1:0] x2;
		logic [SQ2_W-1:0] y2;
		logic [SQ2_W-1:0] pxy;
		logic [S_W-1:0] s;
		logic [SQ_N-1:0] a;
	} side_t;

	// one result beat
	typedef struct packed {
		logic signed [OUT_W-1:0] m00;
		logic signed [OUT_W-1:0] m01;
		logic signed [OUT_W-1:0] m02;
		logic signed [OUT_W-1:0] m10;
		logic signed [OUT_W-1:0] m11;
		logic signed [OUT_W-1:0] m12;
		logic signed [OUT_W-1:0] m20;
		logic signed [OUT_W-1:0] m21;
		logic signed [OUT_W-1:0] m22;
		logic domain_error;
	} result_t;

endpackage

[src/pmm_in_if.sv]
// input channel: pole offset pair
interface pmm_in_if;
	logic valid;
	logic ready;
	logic signed [pmm_pkg::IN_W-1:0] pole_x;
	logic signed [pmm_pkg::IN_W-1:0] pole_y;

	modport source (output valid, output pole_x, output pole_y, input ready);
	modport sink (input valid, input pole_x, input pole_y, output ready);
endinterface

[src/pmm_out_if.sv]
// output channel: rotation matrix and domain flag
interface pmm_out_if;
	logic valid;
	logic ready;
	logic signed [pmm_pkg::OUT_W-1:0] m00;
	logic signed [pmm_pkg::OUT_W-1:0] m01;
	logic signed [pmm_pkg::OUT_W-1:0] m02;
	logic signed [pmm_pkg::OUT_W-1:0] m10;
	logic signed [pmm_pkg::OUT_W-1:0] m11;
	logic signed [pmm_pkg::OUT_W-1:0] m12;
	logic signed [pmm_pkg::OUT_W-1:0] m20;
	logic signed [pmm_pkg::OUT_W-1:0] m21;
	logic signed [pmm_pkg::OUT_W-1:0] m22;
	logic domain_error;

	modport source (output valid, output m00, output m01, output m02, output m10,
		output m11, output m12, output m20, output m21, output m22,
		output domain_error, input ready);
	modport sink (input valid, input m00, input m01, input m02, input m10,
		input m11, input m12, input m20, input m21, input m22,
		input domain_error, output ready);
endinterface

[src/pmm_prod.sv]
// three-stage limb multiplier, 128 x 64 bits unsigned
module pmm_prod (
	input logic clk,
	input logic en,
	input logic [pmm_pkg::PR_A_W-1:0] a,
	input logic [pmm_pkg::PR_B_W-1:0] b,
	output logic [pmm_pkg::PR_P_W-1:0] p
);

	logic [2*pmm_pkg::LIMB_W-1:0] pp_s1 [pmm_pkg::PR_NA][pmm_pkg::PR_NB];
	logic [pmm_pkg::PR_ROW_W-1:0] row_c [pmm_pkg::PR_NA];
	logic [pmm_pkg::PR_ROW_W-1:0] row_s2 [pmm_pkg::PR_NA];
	logic [pmm_pkg::PR_P_W-1:0] sum_c;
	logic [pmm_pkg::PR_P_W-1:0] sum_s3;

	// 32 x 32 partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < pmm_pkg::PR_NA; i++) begin
				for (int j = 0; j < pmm_pkg::PR_NB; j++) begin
					pp_s1[i][j] <= (2*pmm_pkg::LIMB_W)'(a[i*pmm_pkg::LIMB_W +: pmm_pkg::LIMB_W])
						* (2*pmm_pkg::LIMB_W)'(b[j*pmm_pkg::LIMB_W +: pmm_pkg::LIMB_W]);
				end
			end
		end
	end

	// row sums, one per limb of a
	always_comb begin
		for (int i = 0; i < pmm_pkg::PR_NA; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < pmm_pkg::PR_NB; j++) begin
				row_c[i] = row_c[i]
					+ (pmm_pkg::PR_ROW_W'(pp_s1[i][j]) << (j * pmm_pkg::LIMB_W));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s2 <= row_c;
		end
	end

	// final accumulation of the rows
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < pmm_pkg::PR_NA; i++) begin
			sum_c = sum_c + (pmm_pkg::PR_P_W'(row_s2[i]) << (i * pmm_pkg::LIMB_W));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= sum_c;
		end
	end

	assign p = sum_s3;

endmodule

[src/pmm_sqrt.sv]
// pipelined integer square root, one result bit per stage
module pmm_sqrt (
	input logic clk,
	input logic en,
	input logic [pmm_pkg::SQ_W-1:0] v,
	output logic [pmm_pkg::SQ_N-1:0] root
);

	logic [pmm_pkg::SQ_W-1:0] rem_s [pmm_pkg::SQ_N];
	logic [pmm_pkg::SQ_N-1:0] res_s [pmm_pkg::SQ_N];

	for (genvar g = 0; g < pmm_pkg::SQ_N; g++) begin : g_stage
		localparam int B = pmm_pkg::SQ_N - 1 - g;
		logic [pmm_pkg::SQ_W-1:0] rem_in;
		logic [pmm_pkg::SQ_W-1:0] trial;
		logic [pmm_pkg::SQ_N-1:0] res_in;

		if (g == 0) begin : g_first
			assign rem_in = v;
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[g-1];
			assign res_in = res_s[g-1];
		end

		// (res + 2^b)^2 - res^2
		assign trial = (pmm_pkg::SQ_W'(res_in) << (B + 1)) | (pmm_pkg::SQ_W'(1) << (2 * B));

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[g] <= rem_in - trial;
					res_s[g] <= res_in | (pmm_pkg::SQ_N'(1) << B);
				end else begin
					rem_s[g] <= rem_in;
					res_s[g] <= res_in;
				end
			end
		end
	end

	assign root = res_s[pmm_pkg::SQ_N-1];

endmodule

[src/pmm_div.sv]
// pipelined restoring divider, one quotient bit per stage
module pmm_div (
	input logic clk,
	input logic en,
	input logic [pmm_pkg::DIV_NW-1:0] n,
	input logic [pmm_pkg::DIV_DW-1:0] d,
	output logic [pmm_pkg::DIV_N-1:0] q
);

	logic [pmm_pkg::DIV_NW-1:0] r_s [pmm_pkg::DIV_N];
	logic [pmm_pkg::DIV_N-1:0] q_s [pmm_pkg::DIV_N];
	logic [pmm_pkg::DIV_DW-1:0] d_s [pmm_pkg::DIV_N];

	for (genvar g = 0; g < pmm_pkg::DIV_N; g++) begin : g_stage
		localparam int K = pmm_pkg::DIV_N - 1 - g;
		logic [pmm_pkg::DIV_NW-1:0] r_in;
		logic [pmm_pkg::DIV_NW-1:0] ds;
		logic [pmm_pkg::DIV_N-1:0] q_in;
		logic [pmm_pkg::DIV_DW-1:0] d_in;

		if (g == 0) begin : g_first
			assign r_in = n;
			assign q_in = '0;
			assign d_in = d;
		end else begin : g_next
			assign r_in = r_s[g-1];
			assign q_in = q_s[g-1];
			assign d_in = d_s[g-1];
		end

		// divisor aligned to this quotient bit
		assign ds = pmm_pkg::DIV_NW'(d_in) << K;

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[g] <= d_in;
				if (r_in >= ds) begin
					r_s[g] <= r_in - ds;
					q_s[g] <= q_in | (pmm_pkg::DIV_N'(1) << K);
				end else begin
					r_s[g] <= r_in;
					q_s[g] <= q_in;
				end
			end
		end
	end

	assign q = q_s[pmm_pkg::DIV_N-1];

endmodule

[src/polar_motion_matrix.sv]
// polar motion rotation matrix, fully pipelined
// throughput one beat per cycle while the output is not stalled
// depth is set by the 61-stage square root and the 62-stage dividers, plus limb multipliers
// a stalled output freezes the whole pipeline; nothing is lost or repeated
// reset clears only the valid bits; the datapath holds no reset
module polar_motion_matrix (
	input logic clk,
	input logic arst_n,
	pmm_in_if.sink pole,
	pmm_out_if.source matrix
);

	logic adv;
	logic [pmm_pkg::LAT-1:0] vld_s;
	pmm_pkg::side_t side_s [pmm_pkg::LAT];
	pmm_pkg::side_t side_nx [pmm_pkg::LAT];
	pmm_pkg::side_t side_in;
	pmm_pkg::result_t res_c;
	pmm_pkg::result_t out_s;

	logic [pmm_pkg::PR_P_W-1:0] fp_x2;
	logic [pmm_pkg::PR_P_W-1:0] fp_y2;
	logic [pmm_pkg::PR_P_W-1:0] fp_xy;
	logic [pmm_pkg::SQ_W-1:0] sq_v;
	logic [pmm_pkg::SQ_N-1:0] sq_root;
	logic [pmm_pkg::PR_B_W-1:0] one_minus_a;
	logic [pmm_pkg::PR_P_W-1:0] bp_x2a;
	logic [pmm_pkg::PR_P_W-1:0] bp_y2a;
	logic [pmm_pkg::PR_P_W-1:0] bp_g;
	logic [pmm_pkg::DIV_NW-1:0] n00;
	logic [pmm_pkg::DIV_NW-1:0] n11;
	logic [pmm_pkg::DIV_NW-1:0] n01;
	logic [pmm_pkg::DIV_N-1:0] q00;
	logic [pmm_pkg::DIV_N-1:0] q11;
	logic [pmm_pkg::DIV_N-1:0] q01;

	// global advance: move when the output slot is free or being taken
	assign adv = !vld_s[pmm_pkg::LAT-1] || matrix.ready;
	assign pole.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[pmm_pkg::LAT-2:0], pole.valid};
		end
	end

	// input capture: signs and magnitudes
	always_comb begin
		side_in = '0;
		side_in.xs = pole.pole_x;
		side_in.ys = pole.pole_y;
		side_in.xm = pole.pole_x[pmm_pkg::IN_W-1] ? $unsigned(-pole.pole_x)
			: $unsigned(pole.pole_x);
		side_in.ym = pole.pole_y[pmm_pkg::IN_W-1] ? $unsigned(-pole.pole_y)
			: $unsigned(pole.pole_y);
		side_in.negp = pole.pole_x[pmm_pkg::IN_W-1] ^ pole.pole_y[pmm_pkg::IN_W-1];
	end

	// sideband shift line with per-stage updates
	always_comb begin
		side_nx[0] = side_in;
		for (int p = 1; p < pmm_pkg::LAT; p++) begin
			side_nx[p] = side_s[p-1];
		end
		side_nx[pmm_pkg::P_S].x2 = fp_x2[pmm_pkg::SQ2_W-1:0];
		side_nx[pmm_pkg::P_S].y2 = fp_y2[pmm_pkg::SQ2_W-1:0];
		side_nx[pmm_pkg::P_S].pxy = fp_xy[pmm_pkg::SQ2_W-1:0];
		side_nx[pmm_pkg::P_S].s = pmm_pkg::S_W'(fp_x2[pmm_pkg::SQ2_W-1:0])
			+ pmm_pkg::S_W'(fp_y2[pmm_pkg::SQ2_W-1:0]);
		side_nx[pmm_pkg::P_SQ0].tiny = side_s[pmm_pkg::P_S].s
			< pmm_pkg::S_W'(pmm_pkg::TINY_S);
		side_nx[pmm_pkg::P_SQ0].dom = side_s[pmm_pkg::P_S].s >= pmm_pkg::UNIT_S;
		side_nx[pmm_pkg::P_SQL+1].a = sq_root;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s <= side_nx;
		end
	end

	// squares and cross product
	pmm_prod u_px2 (
		.clk(clk), .en(adv),
		.a(pmm_pkg::PR_A_W'(side_s[pmm_pkg::P_IN].xm)),
		.b(pmm_pkg::PR_B_W'(side_s[pmm_pkg::P_IN].xm)),
		.p(fp_x2)
	);
	pmm_prod u_py2 (
		.clk(clk), .en(adv),
		.a(pmm_pkg::PR_A_W'(side_s[pmm_pkg::P_IN].ym)),
		.b(pmm_pkg::PR_B_W'(side_s[pmm_pkg::P_IN].ym)),
		.p(fp_y2)
	);
	pmm_prod u_pxy (
		.clk(clk), .en(adv),
		.a(pmm_pkg::PR_A_W'(side_s[pmm_pkg::P_IN].xm)),
		.b(pmm_pkg::PR_B_W'(side_s[pmm_pkg::P_IN].ym)),
		.p(fp_xy)
	);

	// root operand 1 - s, zero in the domain error case
	assign sq_v = (side_s[pmm_pkg::P_S].s >= pmm_pkg::UNIT_S) ? '0
		: pmm_pkg::SQ_W'(pmm_pkg::UNIT_S - side_s[pmm_pkg::P_S].s);

	pmm_sqrt u_sqrt (
		.clk(clk), .en(adv), .v(sq_v), .root(sq_root)
	);

	// numerator products
	assign one_minus_a = pmm_pkg::ONE_Q - pmm_pkg::PR_B_W'(sq_root);

	pmm_prod u_px2a (
		.clk(clk), .en(adv),
		.a(pmm_pkg::PR_A_W'(side_s[pmm_pkg::P_SQL].x2)),
		.b(pmm_pkg::PR_B_W'(sq_root)),
		.p(bp_x2a)
	);
	pmm_prod u_py2a (
		.clk(clk), .en(adv),
		.a(pmm_pkg::PR_A_W'(side_s[pmm_pkg::P_SQL].y2)),
		.b(pmm_pkg::PR_B_W'(sq_root)),
		.p(bp_y2a)
	);
	pmm_prod u_pg (
		.clk(clk), .en(adv),
		.a(pmm_pkg::PR_A_W'(side_s[pmm_pkg::P_SQL].pxy)),
		.b(one_minus_a),
		.p(bp_g)
	);

	// numerators, all below 2^187
	assign n00 = (pmm_pkg::DIV_NW'(side_s[pmm_pkg::P_BP].y2) << pmm_pkg::FRAC)
		+ pmm_pkg::DIV_NW'(bp_x2a);
	assign n11 = (pmm_pkg::DIV_NW'(side_s[pmm_pkg::P_BP].x2) << pmm_pkg::FRAC)
		+ pmm_pkg::DIV_NW'(bp_y2a);
	assign n01 = pmm_pkg::DIV_NW'(bp_g);

	pmm_div u_d00 (
		.clk(clk), .en(adv), .n(n00), .d(side_s[pmm_pkg::P_BP].s), .q(q00)
	);
	pmm_div u_d11 (
		.clk(clk), .en(adv), .n(n11), .d(side_s[pmm_pkg::P_BP].s), .q(q11)
	);
	pmm_div u_d01 (
		.clk(clk), .en(adv), .n(n01), .d(side_s[pmm_pkg::P_BP].s), .q(q01)
	);

	// result assembly, identity for a tiny offset
	always_comb begin
		res_c.m00 = pmm_pkg::OUT_W'(q00);
		res_c.m11 = pmm_pkg::OUT_W'(q11);
		res_c.m01 = side_s[pmm_pkg::P_DVL].negp ? -pmm_pkg::OUT_W'(q01) : pmm_pkg::OUT_W'(q01);
		res_c.m10 = res_c.m01;
		res_c.m02 = pmm_pkg::OUT_W'(side_s[pmm_pkg::P_DVL].xs);
		res_c.m20 = -pmm_pkg::OUT_W'(side_s[pmm_pkg::P_DVL].xs);
		res_c.m12 = -pmm_pkg::OUT_W'(side_s[pmm_pkg::P_DVL].ys);
		res_c.m21 = pmm_pkg::OUT_W'(side_s[pmm_pkg::P_DVL].ys);
		res_c.m22 = pmm_pkg::OUT_W'(side_s[pmm_pkg::P_DVL].a);
		res_c.domain_error = side_s[pmm_pkg::P_DVL].dom;
		if (side_s[pmm_pkg::P_DVL].tiny) begin
			res_c = '0;
			res_c.m00 = pmm_pkg::ONE_Q;
			res_c.m11 = pmm_pkg::ONE_Q;
			res_c.m22 = pmm_pkg::ONE_Q;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			out_s <= res_c;
		end
	end

	assign matrix.valid = vld_s[pmm_pkg::LAT-1];
	assign matrix.m00 = out_s.m00;
	assign matrix.m01 = out_s.m01;
	assign matrix.m02 = out_s.m02;
	assign matrix.m10 = out_s.m10;
	assign matrix.m11 = out_s.m11;
	assign matrix.m12 = out_s.m12;
	assign matrix.m20 = out_s.m20;
	assign matrix.m21 = out_s.m21;
	assign matrix.m22 = out_s.m22;
	assign matrix.domain_error = out_s.domain_error;

endmodule

[src/pmm_check.sv]
// port checker for the polar motion matrix, bound to the top level
module pmm_check (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [pmm_pkg::OUT_W-1:0] m01,
	input logic [pmm_pkg::OUT_W-1:0] m10,
	input logic [pmm_pkg::OUT_W-1:0] m02,
	input logic [pmm_pkg::OUT_W-1:0] m20,
	input logic [pmm_pkg::OUT_W-1:0] m22,
	input logic domain_error
);

	`include "polar_motion_matrix_macros.svh"

	// a stalled result beat stays offered
	`PMM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
	// an empty output slot never blocks the input
	`PMM_ASSERT_NOW(a_in_free, !out_valid, in_ready, "input stalled with empty output")
	// symmetric pair m01/m10 and antisymmetric pair m02/m20 agree
	`PMM_ASSERT_NOW(a_sym, out_valid, (m01 == m10) && ((m02 + m20) == '0), "matrix symmetry")
	// forced root shows as zero diagonal term
	`PMM_ASSERT_NOW(a_dom, out_valid && domain_error, m22 == '0, "domain flag with root")

endmodule

bind polar_motion_matrix pmm_check u_pmm_check (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(pole.ready),
	.out_valid(matrix.valid),
	.out_ready(matrix.ready),
	.m01(matrix.m01),
	.m10(matrix.m10),
	.m02(matrix.m02),
	.m20(matrix.m20),
	.m22(matrix.m22),
	.domain_error(matrix.domain_error)
);

[test/polar_motion_matrix_tb.sv]
// testbench for the polar motion matrix pipeline: exact integer prediction, random stalls
module polar_motion_matrix_tb;

	typedef struct {
		logic signed [pmm_pkg::IN_W-1:0] x;
		logic signed [pmm_pkg::IN_W-1:0] y;
		int gap;
		bit drain;
	} pole_item_t;

	localparam int LONG_HOLD = 600;
	localparam int HOLD_AT = 300;

	logic clk;
	logic arst_n;
	pmm_in_if pole ();
	pmm_out_if matrix ();

	pole_item_t pole_q[$];
	pmm_pkg::result_t matrix_q[$];
	int idle_left;
	int poles_sent;
	int hold_left;
	int stall_left;
	int beats_seen;
	bit hold_done;
	bit failed;

	polar_motion_matrix dut (
		.clk(clk),
		.arst_n(arst_n),
		.pole(pole.sink),
		.matrix(matrix.source)
	);

	// floor of the square root of a value below 2^122
	function automatic logic [255:0] root_floor(input logic [255:0] v);
		logic [255:0] r;
		logic [255:0] c;
		r = '0;
		for (int b = 60; b >= 0; b--) begin
			c = r | (256'd1 << b);
			if (c * c <= v) r = c;
		end
		return r;
	endfunction

	// exact rotation matrix of one pole offset pair
	function automatic pmm_pkg::result_t rotation_of(
			input logic signed [pmm_pkg::IN_W-1:0] x,
			input logic signed [pmm_pkg::IN_W-1:0] y);
		pmm_pkg::result_t m;
		logic [255:0] xm;
		logic [255:0] ym;
		logic [255:0] x2;
		logic [255:0] y2;
		logic [255:0] s;
		logic [255:0] a;
		logic [255:0] unit;
		logic [255:0] g;
		logic signed [pmm_pkg::OUT_W-1:0] xs;
		logic signed [pmm_pkg::OUT_W-1:0] ys;
		xs = pmm_pkg::OUT_W'(x);
		ys = pmm_pkg::OUT_W'(y);
		xm = x[pmm_pkg::IN_W-1] ? 256'(-xs) : 256'(xs);
		ym = y[pmm_pkg::IN_W-1] ? 256'(-ys) : 256'(ys);
		x2 = xm * xm;
		y2 = ym * ym;
		s = x2 + y2;
		unit = 256'd1 << (2 * pmm_pkg::FRAC);
		m = '0;
		// tiny offset gives the identity
		if (s < 256'(pmm_pkg::TINY_S)) begin
			m.m00 = pmm_pkg::ONE_Q;
			m.m11 = pmm_pkg::ONE_Q;
			m.m22 = pmm_pkg::ONE_Q;
			return m;
		end
		if (s >= unit) begin
			a = '0;
			m.domain_error = 1'b1;
		end else begin
			a = root_floor(unit - s);
		end
		m.m00 = pmm_pkg::OUT_W'(((y2 << pmm_pkg::FRAC) + x2 * a) / s);
		m.m11 = pmm_pkg::OUT_W'(((x2 << pmm_pkg::FRAC) + y2 * a) / s);
		g = (xm * ym * ((256'd1 << pmm_pkg::FRAC) - a)) / s;
		m.m01 = (x[pmm_pkg::IN_W-1] != y[pmm_pkg::IN_W-1]) ? -pmm_pkg::OUT_W'(g)
			: pmm_pkg::OUT_W'(g);
		m.m10 = m.m01;
		m.m02 = xs;
		m.m12 = -ys;
		m.m20 = -xs;
		m.m21 = ys;
		m.m22 = pmm_pkg::OUT_W'(a);
		return m;
	endfunction

	function automatic logic signed [pmm_pkg::IN_W-1:0] rand_code();
		return pmm_pkg::IN_W'({$urandom, $urandom});
	endfunction

	task automatic push_pole(input logic signed [pmm_pkg::IN_W-1:0] x,
			input logic signed [pmm_pkg::IN_W-1:0] y, input int gap, input bit drain);
		pole_item_t it;
		it.x = x;
		it.y = y;
		it.gap = gap;
		it.drain = drain;
		pole_q = {pole_q, it};
	endtask

	// clock and reset
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		fork
			forever #10 clk = ~clk;
		join_none
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// stimulus: directed corners, then random pairs
	initial begin
		logic signed [pmm_pkg::IN_W-1:0] lim_hi;
		logic signed [pmm_pkg::IN_W-1:0] lim_lo;
		logic signed [pmm_pkg::IN_W-1:0] one;
		logic signed [pmm_pkg::IN_W-1:0] x;
		logic signed [pmm_pkg::IN_W-1:0] y;
		int kind;
		lim_hi = {1'b0, {(pmm_pkg::IN_W-1){1'b1}}};
		lim_lo = {1'b1, {(pmm_pkg::IN_W-1){1'b0}}};
		one = pmm_pkg::IN_W'(1) << pmm_pkg::FRAC;
		push_pole(0, 0, 0, 0);
		push_pole(1, -1, 1, 0);
		push_pole(63'sd2305843009, 0, 0, 0);
		push_pole(63'sd2305843010, 0, 2, 0);
		push_pole(0, -63'sd2305843010, 0, 0);
		push_pole(63'sd1630477228, 63'sd1630477228, 0, 0);
		push_pole(one, 0, 3, 0);
		push_pole(0, -one, 0, 0);
		push_pole(one - 1, 0, 0, 0);
		push_pole(-(one - 1), one - 1, 0, 0);
		push_pole(lim_hi, lim_hi, 1, 0);
		push_pole(lim_lo, lim_lo, 0, 0);
		push_pole(lim_hi, lim_lo, 0, 0);
		push_pole(lim_lo, lim_hi, 0, 0);
		push_pole(lim_lo, 0, 5, 0);
		push_pole(0, lim_hi, 0, 0);
		push_pole(63'sd1000000000000, 63'sd2000000000000, 0, 0);
		push_pole(-63'sd1000000000000, 63'sd2000000000000, 0, 0);
		push_pole(63'sd1000000000000000000, -63'sd700000000000000000, 0, 0);
		push_pole(-63'sd1000000000000000000, -63'sd700000000000000000, 0, 1);
		for (int i = 0; i < 1700; i++) begin
			kind = $urandom_range(0, 9);
			x = rand_code();
			y = rand_code();
			case (kind)
				0, 1, 2: begin
				end
				3, 4, 5: begin
					x = x >>> $urandom_range(1, 40);
					y = y >>> $urandom_range(1, 40);
				end
				6: begin
					x = x >>> $urandom_range(28, 62);
					y = y >>> $urandom_range(28, 62);
				end
				7: begin
					// just inside or outside the unit circle
					x = one - pmm_pkg::IN_W'($urandom_range(0, 1 << 20))
						+ pmm_pkg::IN_W'($urandom_range(0, 1 << 10));
					if ($urandom_range(0, 1)) x = -x;
					y = y >>> $urandom_range(20, 62);
				end
				8: x = 0;
				default: y = y >>> $urandom_range(30, 62);
			endcase
			push_pole(x, y, (i >= HOLD_AT && i < HOLD_AT + 300) ? 0 : $urandom_range(0, 19),
				i == 1100);
		end
	end

	// pole driver
	always @(posedge clk or negedge arst_n) begin
		logic show;
		if (!arst_n) begin
			pole.valid <= 1'b0;
			pole.pole_x <= '0;
			pole.pole_y <= '0;
			idle_left = 0;
			poles_sent = 0;
		end else begin
			show = pole.valid;
			if (pole.valid && pole.ready) begin
				matrix_q = {matrix_q, rotation_of(pole_q[0].x, pole_q[0].y)};
				void'(pole_q.pop_front());
				poles_sent++;
				show = 1'b0;
				idle_left = (pole_q.size() > 0) ? pole_q[0].gap : 0;
			end else if (!pole.valid && idle_left > 0) begin
				idle_left--;
			end
			// a drain item waits until every matrix has come back
			if (!show && idle_left == 0 && pole_q.size() > 0
					&& !(pole_q[0].drain && matrix_q.size() > 0)) begin
				pole.pole_x <= pole_q[0].x;
				pole.pole_y <= pole_q[0].y;
				show = 1'b1;
			end
			pole.valid <= show;
		end
	end

	// matrix receiver stalls, with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix.ready <= 1'b0;
			hold_left = 0;
			stall_left = 0;
			hold_done = 1'b0;
		end else if (!hold_done && poles_sent >= HOLD_AT + 20) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
			matrix.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			matrix.ready <= (hold_left == 0);
		end else if (matrix.valid && matrix.ready) begin
			stall_left = (beats_seen > 800 && beats_seen < 1000) ? 0 : $urandom_range(0, 19);
			matrix.ready <= (stall_left == 0);
		end else if (stall_left > 0) begin
			stall_left--;
			matrix.ready <= (stall_left == 0);
		end else begin
			matrix.ready <= 1'b1;
		end
	end

	// matrix checker
	always @(posedge clk or negedge arst_n) begin
		pmm_pkg::result_t want;
		if (!arst_n) begin
			beats_seen = 0;
		end else if (matrix.valid && matrix.ready) begin
			beats_seen++;
			if (matrix_q.size() == 0) begin
				$error("matrix beat with no pole pending");
				failed = 1'b1;
			end else begin
				want = matrix_q.pop_front();
				if (matrix.m00 !== want.m00) begin
					$error("m00 expected %0d got %0d", want.m00, matrix.m00); failed = 1'b1;
				end
				if (matrix.m01 !== want.m01) begin
					$error("m01 expected %0d got %0d", want.m01, matrix.m01); failed = 1'b1;
				end
				if (matrix.m02 !== want.m02) begin
					$error("m02 expected %0d got %0d", want.m02, matrix.m02); failed = 1'b1;
				end
				if (matrix.m10 !== want.m10) begin
					$error("m10 expected %0d got %0d", want.m10, matrix.m10); failed = 1'b1;
				end
				if (matrix.m11 !== want.m11) begin
					$error("m11 expected %0d got %0d", want.m11, matrix.m11); failed = 1'b1;
				end
				if (matrix.m12 !== want.m12) begin
					$error("m12 expected %0d got %0d", want.m12, matrix.m12); failed = 1'b1;
				end
				if (matrix.m20 !== want.m20) begin
					$error("m20 expected %0d got %0d", want.m20, matrix.m20); failed = 1'b1;
				end
				if (matrix.m21 !== want.m21) begin
					$error("m21 expected %0d got %0d", want.m21, matrix.m21); failed = 1'b1;
				end
				if (matrix.m22 !== want.m22) begin
					$error("m22 expected %0d got %0d", want.m22, matrix.m22); failed = 1'b1;
				end
				if (matrix.domain_error !== want.domain_error) begin
					$error("domain_error expected %0b got %0b", want.domain_error,
						matrix.domain_error);
					failed = 1'b1;
				end
			end
		end
	end

	// end of run
	initial begin
		failed = 1'b0;
		repeat (5) @(posedge clk);
		wait (pole_q.size() == 0 && matrix_q.size() == 0);
		repeat (pmm_pkg::LAT + 100) @(posedge clk);
		if (!failed && matrix_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// timeout
	initial begin
		#(20 * 400000);
		$display("Mismatches found");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/pmm_pkg.sv
src/pmm_in_if.sv
src/pmm_out_if.sv
src/pmm_prod.sv
src/pmm_sqrt.sv
src/pmm_div.sv
src/polar_motion_matrix.sv
src/pmm_check.sv
test/polar_motion_matrix_tb.sv
